/* rtl/core/cau_pkg.sv */
// cau_pkg: shared opcodes and default widths for complex_arith_unit.
// No dependencies.
package cau_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;
endpackage

/* rtl/core/cau_ifs.sv */
// cau_ifs: request and response channel interfaces of complex_arith_unit.
// Depends on cau_pkg for default widths.
interface cau_req_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;
	modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] y_re;
	logic signed [DATA_WIDTH-1:0] y_im;
	logic                         overflow;
	logic                         div_by_zero;
	modport source (output valid, y_re, y_im, overflow, div_by_zero, input ready);
	modport sink (input valid, y_re, y_im, overflow, div_by_zero, output ready);
endinterface

/* rtl/core/cau_front.sv */
// cau_front: product, numerator and prep stages (s1..s3) of complex_arith_unit.
// Depends on cau_pkg. Feeds the divider chain a remainder/denominator pair.
module cau_front #(
	parameter int W  = cau_pkg::DATA_WIDTH_DEF,
	parameter int F  = cau_pkg::FRAC_BITS_DEF,
	parameter int RW = 3 * W + F,
	parameter int BW = 2 * W + 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [1:0]          op,
	input  logic signed [W-1:0] a_re,
	input  logic signed [W-1:0] a_im,
	input  logic signed [W-1:0] b_re,
	input  logic signed [W-1:0] b_im,
	output logic                valid_s3,
	output logic [RW-1:0]       rem_re_s3,
	output logic [RW-1:0]       rem_im_s3,
	output logic [2*W-1:0]      den_s3,
	output logic [BW-1:0]       bund_s3
);
	localparam logic signed [2*W:0] SMAX = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [2*W:0] SMIN = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};

	logic                  valid_s1, valid_s2;
	logic [1:0]            op_s1, op_s2;
	logic signed [2*W-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [W:0]     sre_s1, sim_s1, sre_s2, sim_s2;
	logic signed [2*W:0]   nre_s2, nim_s2;
	logic [2*W-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op;
			ac_s1  <= a_re * b_re;
			bd_s1  <= a_im * b_im;
			ad_s1  <= a_re * b_im;
			bc_s1  <= a_im * b_re;
			cc_s1  <= b_re * b_re;
			dd_s1  <= b_im * b_im;
			sre_s1 <= (op == cau_pkg::OP_SUB) ? (W+1)'(a_re) - (W+1)'(b_re)
			                                  : (W+1)'(a_re) + (W+1)'(b_re);
			sim_s1 <= (op == cau_pkg::OP_SUB) ? (W+1)'(a_im) - (W+1)'(b_im)
			                                  : (W+1)'(a_im) + (W+1)'(b_im);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			sre_s2 <= sre_s1;
			sim_s2 <= sim_s1;
			nre_s2 <= (op_s1 == cau_pkg::OP_MUL) ? (2*W+1)'(ac_s1) - (2*W+1)'(bd_s1)
			                                     : (2*W+1)'(ac_s1) + (2*W+1)'(bd_s1);
			nim_s2 <= (op_s1 == cau_pkg::OP_MUL) ? (2*W+1)'(ad_s1) + (2*W+1)'(bc_s1)
			                                     : (2*W+1)'(bc_s1) - (2*W+1)'(ad_s1);
			den_s2 <= $unsigned(cc_s1) + $unsigned(dd_s1);
		end
	end

	logic [2*W:0]        mre, mim;
	logic [RW-1:0]       dre, dim, dsh;
	logic signed [2*W:0] vre, vim;
	logic [W-1:0]        yre, yim;
	logic                ovf, big_re, big_im, dz, is_div;

	always_comb begin
		mre    = nre_s2[2*W] ? (2*W+1)'(-nre_s2) : nre_s2;
		mim    = nim_s2[2*W] ? (2*W+1)'(-nim_s2) : nim_s2;
		dre    = {{(RW-2*W-1){1'b0}}, mre} << F;
		dim    = {{(RW-2*W-1){1'b0}}, mim} << F;
		dsh    = {{(RW-2*W){1'b0}}, den_s2} << W;
		big_re = dre >= dsh;
		big_im = dim >= dsh;
		dz     = den_s2 == '0;
		is_div = op_s2 == cau_pkg::OP_DIV;
		case (op_s2)
			cau_pkg::OP_MUL: begin
				vre = nre_s2 >>> F;
				vim = nim_s2 >>> F;
			end
			default: begin
				vre = {{W{sre_s2[W]}}, sre_s2};
				vim = {{W{sim_s2[W]}}, sim_s2};
			end
		endcase
		ovf = 1'b0;
		if (vre > SMAX) begin
			yre = SMAX[W-1:0];
			ovf = 1'b1;
		end else if (vre < SMIN) begin
			yre = SMIN[W-1:0];
			ovf = 1'b1;
		end else begin
			yre = vre[W-1:0];
		end
		if (vim > SMAX) begin
			yim = SMAX[W-1:0];
			ovf = 1'b1;
		end else if (vim < SMIN) begin
			yim = SMIN[W-1:0];
			ovf = 1'b1;
		end else begin
			yim = vim[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_s3 <= dre;
			rem_im_s3 <= dim;
			den_s3    <= den_s2;
			bund_s3   <= {is_div, is_div & dz, nre_s2[2*W], nim_s2[2*W], big_re, big_im,
			              ovf, yre, yim};
		end
	end
endmodule

/* rtl/core/cau_div_step.sv */
// cau_div_step: one restoring-division stage, resolves quotient bit K for both parts.
// Depends on nothing; chained W times by complex_arith_unit.
module cau_div_step #(
	parameter int W  = 16,
	parameter int RW = 56,
	parameter int BW = 39,
	parameter int K  = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  logic [RW-1:0]  rem_re_in,
	input  logic [RW-1:0]  rem_im_in,
	input  logic [W-1:0]   q_re_in,
	input  logic [W-1:0]   q_im_in,
	input  logic [2*W-1:0] den_in,
	input  logic [BW-1:0]  bund_in,
	output logic           valid_out,
	output logic [RW-1:0]  rem_re_out,
	output logic [RW-1:0]  rem_im_out,
	output logic [W-1:0]   q_re_out,
	output logic [W-1:0]   q_im_out,
	output logic [2*W-1:0] den_out,
	output logic [BW-1:0]  bund_out
);
	logic [RW-1:0] dsh, nre, nim;
	logic [W-1:0]  qre, qim;

	always_comb begin
		dsh = {{(RW-2*W){1'b0}}, den_in} << K;
		nre = rem_re_in;
		nim = rem_im_in;
		qre = q_re_in;
		qim = q_im_in;
		if (rem_re_in >= dsh) begin
			nre    = rem_re_in - dsh;
			qre[K] = 1'b1;
		end
		if (rem_im_in >= dsh) begin
			nim    = rem_im_in - dsh;
			qim[K] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_out <= nre;
			rem_im_out <= nim;
			q_re_out   <= qre;
			q_im_out   <= qim;
			den_out    <= den_in;
			bund_out   <= bund_in;
		end
	end
endmodule

/* rtl/core/complex_arith_unit.sv */
// complex_arith_unit: pipelined complex add/sub/mul/div on signed fixed point.
// Depends on cau_pkg, cau_ifs, cau_front, cau_div_step.
// One transaction is accepted every cycle while the response side is not stalled; each result
// passes three front stages, one restoring-division stage per quotient bit and one output
// register, the same for every opcode so results stay in order.
// A stall on the response side holds the whole pipeline; req.ready follows it.
module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);
	localparam int W  = DATA_WIDTH;
	localparam int RW = 3 * W + FRAC_BITS;
	localparam int BW = 2 * W + 7;

	logic en;
	logic          v   [0:W];
	logic [RW-1:0] rre [0:W];
	logic [RW-1:0] rim [0:W];
	logic [W-1:0]  qre [0:W];
	logic [W-1:0]  qim [0:W];
	logic [2*W-1:0] den [0:W];
	logic [BW-1:0] bnd [0:W];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;
	assign qre[0]    = '0;
	assign qim[0]    = '0;

	cau_front #(.W(W), .F(FRAC_BITS), .RW(RW), .BW(BW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(req.valid), .op(req.req_type),
		.a_re(req.a_re), .a_im(req.a_im), .b_re(req.b_re), .b_im(req.b_im),
		.valid_s3(v[0]), .rem_re_s3(rre[0]), .rem_im_s3(rim[0]), .den_s3(den[0]),
		.bund_s3(bnd[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_div
		cau_div_step #(.W(W), .RW(RW), .BW(BW), .K(W - 1 - i)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v[i]),
			.rem_re_in(rre[i]), .rem_im_in(rim[i]), .q_re_in(qre[i]), .q_im_in(qim[i]),
			.den_in(den[i]), .bund_in(bnd[i]),
			.valid_out(v[i+1]), .rem_re_out(rre[i+1]), .rem_im_out(rim[i+1]),
			.q_re_out(qre[i+1]), .q_im_out(qim[i+1]), .den_out(den[i+1]),
			.bund_out(bnd[i+1])
		);
	end

	localparam logic [W-1:0] LIM  = {1'b1, {(W - 1){1'b0}}};
	localparam logic [W-1:0] PMAX = {1'b0, {(W - 1){1'b1}}};

	logic         is_div, dz, neg_re, neg_im, big_re, big_im, povf, ovf;
	logic [W-1:0] pre, pim, yre, yim, q_re, q_im;

	always_comb begin
		{is_div, dz, neg_re, neg_im, big_re, big_im, povf, pre, pim} = bnd[W];
		q_re = qre[W];
		q_im = qim[W];
		yre  = pre;
		yim  = pim;
		ovf  = povf;
		if (is_div) begin
			ovf = 1'b0;
			if (dz) begin
				yre = '0;
				yim = '0;
			end else begin
				if (neg_re) begin
					if (big_re || q_re > LIM) begin
						yre = LIM;
						ovf = 1'b1;
					end else begin
						yre = -q_re;
					end
				end else if (big_re || q_re > PMAX) begin
					yre = PMAX;
					ovf = 1'b1;
				end else begin
					yre = q_re;
				end
				if (neg_im) begin
					if (big_im || q_im > LIM) begin
						yim = LIM;
						ovf = 1'b1;
					end else begin
						yim = -q_im;
					end
				end else if (big_im || q_im > PMAX) begin
					yim = PMAX;
					ovf = 1'b1;
				end else begin
					yim = q_im;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= v[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.y_re        <= yre;
			rsp.y_im        <= yim;
			rsp.overflow    <= ovf;
			rsp.div_by_zero <= is_div & dz;
		end
	end

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_by_zero |-> rsp.y_re == '0 && rsp.y_im == '0 && !rsp.overflow)
		else $error("divide by zero result not cleared");
	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		v[W] && !bnd[W][BW-1] |-> !bnd[W][BW-2])
		else $error("divide-by-zero flag on a non-divide transaction");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready ##1
		(rsp.valid && $stable(rsp.y_re) && $stable(rsp.y_im)))
		else $error("response dropped or request taken during stall");
endmodule
